// ===== rtl/itst_pkg.sv =====
// ---------------------------------------------------------------------------
// itst_pkg
// shared types and constants for the interval timing statistics table
// ---------------------------------------------------------------------------
package itst_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TIME_W     = 64;
    localparam int SLOT_W     = 7;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [1:0] {
        MODE_BEGIN = 2'd0,
        MODE_END   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        t_time sum;
        t_time hits;
        t_time min;
        t_time max;
        t_time last;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_entry data;
    } t_wr_req;

endpackage

// ===== rtl/interval_timing_stats_table.sv =====
// ---------------------------------------------------------------------------
// interval_timing_stats_table
// per-slot interval timing statistics kept in a read-modify-write memory
// ---------------------------------------------------------------------------
// Each request (begin, end, read or clear of one slot) gives one result. A
// request passes through the slot memory read, the forming of the interval
// delta in the fetch state, and the update and write back of the slot entry,
// which loads the result; a new request is taken only once back in idle.
// The update waits while the output register still holds an unaccepted
// result. The result sits in an output register, so a new request is taken
// while the previous result waits. After reset the table reads as zero at
// once through per-slot valid bits; there is no clearing pass.
// ---------------------------------------------------------------------------
module interval_timing_stats_table
    import itst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [63:0]       i_now_time,
    input  logic [63:0]       i_start_time,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_status,
    output logic [63:0]       o_value,
    output logic [63:0]       o_sum_time,
    output logic [63:0]       o_hit_total,
    output logic [63:0]       o_min_time,
    output logic [63:0]       o_max_time,
    output logic [63:0]       o_last_begin
);

    t_state            r_state, n_state;
    t_mode             r_mode;
    logic [SLOT_W-1:0] r_slot;
    t_time             r_now, r_start, r_delta, n_delta;

    logic   r_out_valid, r_out_status;
    t_time  r_out_value;
    t_entry r_out_stats;

    logic    w_accept, w_slot_ok, w_out_free, w_load_out;
    t_entry  w_cur, w_new, w_out_stats;
    t_time   w_hits_inc, w_out_value;
    t_wr_req w_wr;

    assign w_accept   = i_valid && o_ready;
    assign w_slot_ok  = (32'(r_slot) < SLOT_COUNT);
    assign w_out_free = !r_out_valid || i_ready;
    assign n_delta    = (r_now >= r_start) ? (r_now - r_start) : '0;

    itst_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (ADDR_W'(i_slot)),
        .i_wr      (w_wr),
        .o_rd_data (w_cur)
    );

    always_comb begin
        w_hits_inc = w_cur.hits + 64'd1;
        w_new      = w_cur;
        w_out_stats = '0;
        w_out_value = '0;
        unique case (r_mode)
            MODE_BEGIN: begin
                w_new.last  = r_now;
                w_out_value = w_slot_ok ? r_now : '0;
            end
            MODE_END: begin
                w_new.sum  = w_cur.sum + r_delta;
                w_new.hits = w_hits_inc;
                if (w_hits_inc == 64'd1 || r_delta < w_cur.min) begin
                    w_new.min = r_delta;
                end
                if (r_delta > w_cur.max) begin
                    w_new.max = r_delta;
                end
                w_out_value = r_delta;
            end
            MODE_READ: begin
                if (w_slot_ok) begin
                    w_out_stats = w_cur;
                end
            end
            MODE_CLEAR: begin
                w_new = '0;
            end
            default: begin
                w_new = w_cur;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        w_load_out = 1'b0;
        w_wr.en    = 1'b0;
        w_wr.addr  = ADDR_W'(r_slot);
        w_wr.data  = w_new;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_wr.en    = w_slot_ok && (r_mode != MODE_READ);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= t_mode'(i_mode);
            r_slot  <= i_slot;
            r_now   <= i_now_time;
            r_start <= i_start_time;
        end
        if (r_state == ST_FETCH) begin
            r_delta <= n_delta;
        end
        if (w_load_out) begin
            r_out_status <= !w_slot_ok;
            r_out_value  <= w_out_value;
            r_out_stats  <= w_out_stats;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_value      = r_out_value;
    assign o_sum_time   = r_out_stats.sum;
    assign o_hit_total  = r_out_stats.hits;
    assign o_min_time   = r_out_stats.min;
    assign o_max_time   = r_out_stats.max;
    assign o_last_begin = r_out_stats.last;

    a_fetch_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FETCH |-> $past(i_valid && o_ready))
        else $error("fetch without accepted request");

    a_no_write_bad_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE && !w_slot_ok) |-> !w_wr.en)
        else $error("write to out-of-range slot");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_UPDATE))
        else $error("result not produced by update");

    a_bad_slot_zero_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_sum_time == '0 && o_hit_total == '0 &&
            o_min_time == '0 && o_max_time == '0 && o_last_begin == '0))
        else $error("statistics returned for out-of-range slot");

endmodule

// ===== rtl/itst_store.sv =====
// ---------------------------------------------------------------------------
// itst_store
// slot statistics memory with registered read and per-entry valid
// bits; an entry never written since reset reads as zero
// ---------------------------------------------------------------------------
module itst_store
    import itst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rd_en,
    input  t_addr   i_rd_addr,
    input  t_wr_req i_wr,
    output t_entry  o_rd_data
);

    t_entry                mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;
    t_entry                r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
